FILE: hdl/apq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_pkg
// Shared constants for the ascending priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int ECOUNT_W = 5;
	localparam int MTDATA_W = 40;

	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam logic    MODE_INSERT  = 1'b0;
	localparam logic    MODE_REMOVE  = 1'b1;

	localparam status_t STATUS_DONE  = 2'd0;
	localparam status_t STATUS_FULL  = 2'd1;
	localparam status_t STATUS_EMPTY = 2'd2;

endpackage

FILE: hdl/apq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module apq_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  apq_pkg::value_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output apq_pkg::value_t rd_data
);
	import apq_pkg::*;

	value_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: hdl/ascending_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_priority_queue_unit
// Unordered-array priority queue: insert appends, remove returns the minimum.
// ----------------------------------------------------------------------------
//  channel  dir  fields (lsb up)
//  s_*      in   tdata: value[31:0]      tuser: mode
//  m_*      out  tdata: removed_value[31:0], entry_count[36:32], zero pad
//                tuser: status[1:0]
//
//  Insert, or removal on empty, goes straight to the result. Remove scans the
//  n entries for the minimum at place k, then shifts the entries above k down
//  by one, both through the single read port of the entry store: one read per
//  cycle for the scan, then for the shift.
//  One item at a time; a finished result waits in the output register while
//  the next item is taken. arst_n clears the count, control and valid flags;
//  entry contents are undefined until written.
// ----------------------------------------------------------------------------
module ascending_priority_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  apq_pkg::value_t              s_tdata,  // value
	input  logic                         s_tuser,  // mode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [apq_pkg::MTDATA_W-1:0] m_tdata,  // removed_value, entry_count
	output apq_pkg::status_t             m_tuser   // status
);
	import apq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]  state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic          pend_s1;
	logic [CW-1:0] pidx_s1;
	value_t        min_q;
	logic [CW-1:0] best_q;
	status_t       res_status_q;
	value_t        res_value_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	value_t        wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	value_t        rd_data;

	logic          take;
	value_t        new_min;
	logic [CW-1:0] new_best;
	logic [CW+4:0] count_ext;
	logic          accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	apq_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		take     = (pidx_s1 == '0) || ($signed(rd_data) < $signed(min_q));
		new_min  = take ? rd_data : min_q;
		new_best = take ? pidx_s1 : best_q;
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = s_tdata;
		rd_en   = 1'b0;
		rd_addr = ptr_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				wr_en = accept && (s_tuser == MODE_INSERT) && (count_q < CW'(DEPTH));
			end
			ST_SCAN: begin
				rd_en = (ptr_q < count_q);
			end
			ST_SHIFT: begin
				rd_en   = (ptr_q < count_q);
				wr_en   = pend_s1;
				wr_addr = pidx_s1[AW-1:0];
				wr_data = rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pend_s1 <= 1'b0;
						ptr_q   <= '0;
						if (s_tuser == MODE_INSERT) begin
							if (count_q < CW'(DEPTH)) begin
								count_q <= count_q + 1'b1;
							end
							state_q <= ST_DONE;
						end else if (count_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (pend_s1 && (pidx_s1 == count_q - 1'b1)) begin
						ptr_q   <= new_best + 1'b1;
						pend_s1 <= 1'b0;
						state_q <= ST_SHIFT;
					end else if (ptr_q < count_q) begin
						ptr_q   <= ptr_q + 1'b1;
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
				end
				ST_SHIFT: begin
					if (ptr_q < count_q) begin
						ptr_q   <= ptr_q + 1'b1;
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						count_q <= count_q - 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan and shift tracking, result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_value_q <= '0;
					if (s_tuser == MODE_INSERT) begin
						res_status_q <= (count_q < CW'(DEPTH)) ? STATUS_DONE : STATUS_FULL;
					end else begin
						res_status_q <= (count_q == '0) ? STATUS_EMPTY : STATUS_DONE;
					end
				end
			end
			ST_SCAN: begin
				pidx_s1 <= ptr_q;
				if (pend_s1) begin
					min_q  <= new_min;
					best_q <= new_best;
					if (pidx_s1 == count_q - 1'b1) begin
						res_value_q <= new_min;
					end
				end
			end
			ST_SHIFT: begin
				pidx_s1 <= ptr_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign count_ext = {5'b0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!m_tvalid || m_tready)) begin
			m_tdata <= {3'b0, count_ext[ECOUNT_W-1:0], res_value_q};
			m_tuser <= res_status_q;
		end
	end

endmodule
